// ===== hw/rtl/vphc_pkg.sv =====
// package for the vorbis private header check: payload types, codes and signature table
`timescale 1ns / 1ps

package vphc_pkg;

   localparam int DEFAULT_LENGTH_BITS = 24;
   localparam int OUT_BITS = 24;
   localparam int HDR_COUNT = 2;
   localparam int ID_LEN = 30;
   localparam int MIN_HDR = 7;
   localparam int LACE_CONT = 255;

   localparam logic [7:0] KIND_ID = 8'h01;
   localparam logic [7:0] KIND_COMMENT = 8'h03;
   localparam logic [7:0] KIND_SETUP = 8'h05;

   typedef enum logic [3:0] {
      ERR_NONE        = 4'd0,
      ERR_COUNT       = 4'd1,
      ERR_ID_LEN      = 4'd2,
      ERR_TRUNCATED   = 4'd3,
      ERR_COMMENT_LEN = 4'd4,
      ERR_ID_SIG      = 4'd5,
      ERR_COMMENT_SIG = 4'd6,
      ERR_SETUP_LEN   = 4'd7,
      ERR_SETUP_SIG   = 4'd8,
      ERR_OVERFLOW    = 4'd9
   } err_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                header_valid;
      logic [3:0]          error_code;
      logic [OUT_BITS-1:0] comment_length;
      logic [OUT_BITS-1:0] setup_length;
   } rsp_type;

   // packet type byte then "vorbis"
   function automatic logic [7:0] sig_byte(input logic [7:0] kind, input logic [2:0] k);
      logic [7:0] b;
      case (k)
         3'd0: b = kind;
         3'd1: b = 8'h76;
         3'd2: b = 8'h6f;
         3'd3: b = 8'h72;
         3'd4: b = 8'h62;
         3'd5: b = 8'h69;
         3'd6: b = 8'h73;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== hw/rtl/vorbis_private_header_check.sv =====
// A byte is taken into the input register in_ff; a last byte's verdict is registered in rsp_ff.
// Throughput: one byte per cycle, set by the single registered check stage; only a last byte
// waits, and only while the previous verdict is still held in the output register.
// Reset (synchronous, active high) returns the parser to the header count byte,
// clears the counters and the latched error, and empties both stages.
// The parser also clears itself after the last byte of every buffer.
`timescale 1ns / 1ps

module vorbis_private_header_check
   import vphc_pkg::*;
#(
   parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int L = LENGTH_BITS;
   localparam int DW = L + 2;
   localparam int WW = (L > OUT_BITS) ? L : OUT_BITS;

   typedef enum logic [1:0] {
      PH_COUNT,
      PH_IDLEN,
      PH_LACE,
      PH_BODY
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [L-1:0] pos_ff, pos_in;
   logic [L-1:0] sum_ff, sum_in;
   logic [L:0]   setup_start_ff, setup_start_in;
   logic [L-1:0] rel_ff, rel_in;
   err_type     err_ff, err_in;
   logic        in_valid_ff, in_valid_in;
   req_type     in_ff, in_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic s1_advance;
   logic s1_fire;

   assign s1_advance = !in_ff.last_byte || !rsp_valid_ff || rsp_ready;
   assign s1_fire = in_valid_ff && s1_advance;
   assign req_ready = !in_valid_ff || s1_advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      logic          pos_sat;
      logic [L:0]    sum_add;
      logic [L-1:0]  rel_id;
      logic [DW-1:0] diff;
      logic          diff_in_sig;
      logic [L-1:0]  setup_bytes;
      logic [WW-1:0] sum_wide;
      logic [WW-1:0] setup_wide;
      err_type       err_now;
      logic [7:0]    b;

      pos_sat = &pos_ff;
      b = in_ff.data_byte;
      sum_add = {1'b0, sum_ff} + (L + 1)'(b);
      rel_id = rel_ff - L'(ID_LEN);
      diff = {2'b00, rel_ff} - {1'b0, setup_start_ff};
      diff_in_sig = !diff[DW-1] && (diff < DW'(MIN_HDR));
      setup_bytes = diff[L-1:0] + L'(1);
      sum_wide = WW'(sum_ff);
      setup_wide = WW'(setup_bytes);

      phase_in = phase_ff;
      pos_in = pos_ff;
      sum_in = sum_ff;
      setup_start_in = setup_start_ff;
      rel_in = rel_ff;
      err_in = err_ff;
      in_valid_in = in_valid_ff;
      in_in = in_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      err_now = err_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (s1_fire) begin
         if (pos_sat) begin
            if (err_now == ERR_NONE) begin
               err_now = ERR_OVERFLOW;
            end
         end else begin
            pos_in = pos_ff + L'(1);
            if (phase_ff == PH_BODY) begin
               rel_in = rel_ff + L'(1);
            end
         end

         if (err_now == ERR_NONE) begin
            case (phase_ff)
               PH_COUNT: begin
                  if (b != 8'(HDR_COUNT)) err_now = ERR_COUNT;
                  else if (in_ff.last_byte) err_now = ERR_TRUNCATED;
                  else phase_in = PH_IDLEN;
               end
               PH_IDLEN: begin
                  if (b != 8'(ID_LEN)) err_now = ERR_ID_LEN;
                  else if (in_ff.last_byte) err_now = ERR_TRUNCATED;
                  else phase_in = PH_LACE;
               end
               PH_LACE: begin
                  if (in_ff.last_byte) begin
                     err_now = ERR_TRUNCATED;
                  end else if (sum_add[L]) begin
                     err_now = ERR_OVERFLOW;
                  end else begin
                     sum_in = sum_add[L-1:0];
                     if (b != 8'(LACE_CONT)) begin
                        if (sum_add[L-1:0] < L'(MIN_HDR)) begin
                           err_now = ERR_COMMENT_LEN;
                        end else begin
                           phase_in = PH_BODY;
                           rel_in = '0;
                           setup_start_in = sum_add + (L + 1)'(ID_LEN);
                        end
                     end
                  end
               end
               PH_BODY: begin
                  if (rel_ff < L'(MIN_HDR)) begin
                     if (b != sig_byte(KIND_ID, rel_ff[2:0])) err_now = ERR_ID_SIG;
                  end else if (rel_ff >= L'(ID_LEN) && rel_ff < L'(ID_LEN + MIN_HDR)) begin
                     if (b != sig_byte(KIND_COMMENT, rel_id[2:0])) err_now = ERR_COMMENT_SIG;
                  end else if (diff_in_sig) begin
                     if (b != sig_byte(KIND_SETUP, diff[2:0])) err_now = ERR_SETUP_SIG;
                  end
               end
               default: begin
                  err_now = err_ff;
               end
            endcase
         end

         err_in = err_now;

         if (in_ff.last_byte) begin
            if (phase_ff == PH_BODY &&
                (err_now == ERR_NONE || err_now == ERR_SETUP_SIG)) begin
               if (err_now == ERR_NONE && rel_ff < L'(ID_LEN + MIN_HDR - 1)) begin
                  err_now = ERR_TRUNCATED;
               end else if (diff[DW-1] || diff < DW'(MIN_HDR - 1)) begin
                  err_now = ERR_SETUP_LEN;
               end
            end
            rsp_valid_in = 1'b1;
            rsp_in.header_valid = (err_now == ERR_NONE);
            rsp_in.error_code = err_now;
            rsp_in.comment_length = (err_now == ERR_NONE) ? sum_wide[OUT_BITS-1:0] : '0;
            rsp_in.setup_length = (err_now == ERR_NONE) ? setup_wide[OUT_BITS-1:0] : '0;

            phase_in = PH_COUNT;
            pos_in = '0;
            sum_in = '0;
            setup_start_in = '0;
            rel_in = '0;
            err_in = ERR_NONE;
         end
      end

      if (req_ready) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_in = req_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COUNT;
         pos_ff <= '0;
         sum_ff <= '0;
         setup_start_ff <= '0;
         rel_ff <= '0;
         err_ff <= ERR_NONE;
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         setup_start_ff <= setup_start_in;
         rel_ff <= rel_in;
         err_ff <= err_in;
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_ff <= in_in;
      rsp_ff <= rsp_in;
   end

   a_valid_means_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.header_valid |-> rsp_ff.error_code == ERR_NONE)
      else $error("verdict passes with an error code");

   a_fail_zero_lengths: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.header_valid |->
         rsp_ff.comment_length == '0 && rsp_ff.setup_length == '0)
      else $error("failed verdict carries lengths");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      s1_fire && in_ff.last_byte |=>
         phase_ff == PH_COUNT && pos_ff == '0 && err_ff == ERR_NONE)
      else $error("parser not cleared after last byte");

   a_body_min_comment: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> sum_ff >= L'(MIN_HDR))
      else $error("body phase with short comment header");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !s1_advance |=> in_valid_ff && $stable(in_ff))
      else $error("stalled byte lost from check stage");

endmodule
